// File: src/master_gain_soft_clip_peak_defines.svh
// ----------------------------------------------------------------------------
// master gain soft clip peak: assertion macros
// shared concurrent check forms, clocked on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef MASTER_GAIN_SOFT_CLIP_PEAK_DEFINES_SVH
`define MASTER_GAIN_SOFT_CLIP_PEAK_DEFINES_SVH

// same-cycle implication
`define MGSCP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MGSCP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/mgscp_pkg.sv
// ----------------------------------------------------------------------------
// mgscp_pkg
// shared constants and types of the master gain, soft clip and peak block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mgscp_pkg;

    localparam int GAIN_W    = 16;
    localparam int GAIN_FRAC = 14;
    localparam int MUL_CNT_W = $clog2(GAIN_W);

    localparam logic [GAIN_W-1:0] GAIN_MAX   = 16'd32768;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// File: src/mgscp_recip.sv
// ----------------------------------------------------------------------------
// mgscp_recip
// restoring divider for 2^(2F) / d, one quotient bit per cycle, d > 2^F
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "master_gain_soft_clip_peak_defines.svh"

module mgscp_recip
    import mgscp_pkg::*;
#(
    parameter int FRACTION_BITS = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [FRACTION_BITS+3:0]   i_divisor,
    output logic [FRACTION_BITS-1:0]   o_quot,
    output t_div_stat                  o_stat
);

    localparam int D_W   = FRACTION_BITS + 4;
    localparam int CNT_W = $clog2(FRACTION_BITS);

    localparam logic [D_W-1:0] REM_INIT = D_W'(1) << FRACTION_BITS;

    logic                     r_busy, n_busy;
    logic                     r_done, n_done;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [D_W-1:0]           r_rem, n_rem;
    logic [D_W-1:0]           r_div, n_div;
    logic [FRACTION_BITS-1:0] r_quot, n_quot;

    logic [D_W:0] rem_two;
    logic [D_W:0] rem_sub;
    logic         q_bit;

    always_comb begin
        rem_two = {r_rem, 1'b0};
        rem_sub = rem_two - {1'b0, r_div};
        q_bit   = (rem_two >= {1'b0, r_div});

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_div  = r_div;
        n_quot = r_quot;

        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(FRACTION_BITS - 1);
            n_rem  = REM_INIT;
            n_div  = i_divisor;
        end else if (r_busy) begin
            n_rem  = q_bit ? rem_sub[D_W-1:0] : rem_two[D_W-1:0];
            n_quot = {r_quot[FRACTION_BITS-2:0], q_bit};
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_quot <= n_quot;
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    `MGSCP_ASSERT_IMP(a_start_div_big, i_start, i_divisor > REM_INIT, "divisor not above one")
    `MGSCP_ASSERT_IMP(a_rem_below_div, r_busy, r_rem < r_div, "remainder not below divisor")
    `MGSCP_ASSERT_NXT(a_last_step_done, r_busy && !i_start && r_cnt == '0, r_done && !r_busy,
        "divider did not finish")

endmodule

// File: src/master_gain_soft_clip_peak.sv
// ----------------------------------------------------------------------------
// master_gain_soft_clip_peak
// master gain, saturation, 1/y soft clip and per-block peak meter
// ----------------------------------------------------------------------------
// data path: an input beat steps through IDLE, MUL and SAT, then through DIV when the
//   soft clip divider runs, and OUT, which waits for a free output register
// sample flow: one sample at a time, a new beat is taken only in IDLE; paced by
//   the 16-step shift-add gain multiplier and the bit-serial reciprocal divider
// reset: synchronous, active low; gain back to unity, peak cleared, no beat out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "master_gain_soft_clip_peak_defines.svh"

module master_gain_soft_clip_peak
    import mgscp_pkg::*;
#(
    parameter int FRACTION_BITS = 20
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    // config write channel: master_gain
    input  logic                                          i_cfg_valid,
    output logic                                          o_cfg_ready,
    input  logic [GAIN_W-1:0]                             i_cfg_data,
    // input stream
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // tdata: mixed_sample
    input  logic [((FRACTION_BITS+4+7)/8)*8-1:0]          s_axis_tdata,
    // tlast: last_of_block
    input  logic                                          s_axis_tlast,
    // output stream
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // tdata: clipped_sample, block_peak
    output logic [((2*FRACTION_BITS+3+7)/8)*8-1:0]        m_axis_tdata,
    // tlast: peak_valid
    output logic                                          m_axis_tlast
);

    localparam int IN_W        = FRACTION_BITS + 4;
    localparam int OUT_W       = FRACTION_BITS + 2;
    localparam int PEAK_W      = FRACTION_BITS + 1;
    localparam int ACC_W       = IN_W + GAIN_W;
    localparam int FLR_W       = ACC_W - GAIN_FRAC;
    localparam int Q_W         = FLR_W + 1;
    localparam int OUT_TDATA_W = ((OUT_W + PEAK_W + 7) / 8) * 8;

    localparam logic [Q_W-1:0]    SAT_NEG = Q_W'(1) << (FRACTION_BITS + 3);
    localparam logic [Q_W-1:0]    SAT_POS = SAT_NEG - Q_W'(1);
    localparam logic [PEAK_W-1:0] ONE_Q   = PEAK_W'(1) << FRACTION_BITS;
    localparam logic [IN_W-1:0]   ONE_IN  = IN_W'(1) << FRACTION_BITS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL  = 3'd1;
    localparam logic [2:0] ST_SAT  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]           r_state, n_state;
    logic [GAIN_W-1:0]    r_gain, n_gain;
    logic [MUL_CNT_W-1:0] r_cnt, n_cnt;
    logic [ACC_W-1:0]     r_prod, n_prod;
    logic [IN_W-1:0]      r_mag, n_mag;
    logic                 r_neg, n_neg;
    logic                 r_last, n_last;
    logic [PEAK_W-1:0]    r_omag, n_omag;
    logic [PEAK_W-1:0]    r_peak, n_peak;
    logic                 r_o_valid, n_o_valid;
    logic [OUT_W-1:0]     r_o_sample, n_o_sample;
    logic [PEAK_W-1:0]    r_o_peak, n_o_peak;
    logic                 r_o_last, n_o_last;

    logic [IN_W-1:0]          in_x;
    logic [IN_W:0]            mul_sum;
    logic [Q_W-1:0]           q_mag;
    logic [Q_W-1:0]           q_lim;
    logic [Q_W-1:0]           q_sat;
    logic [IN_W-1:0]          y_mag;
    logic                     div_start;
    logic [FRACTION_BITS-1:0] div_quot;
    t_div_stat                div_stat;
    logic [PEAK_W-1:0]        peak_max;
    logic                     in_beat;
    logic                     out_free;

    mgscp_recip #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (y_mag),
        .o_quot    (div_quot),
        .o_stat    (div_stat)
    );

    always_comb begin
        in_x    = s_axis_tdata[IN_W-1:0];
        in_beat = s_axis_tvalid && (r_state == ST_IDLE);
        out_free = !r_o_valid || m_axis_tready;

        // shift-add step: add multiplicand to the high half, shift right
        mul_sum = {1'b0, r_prod[ACC_W-1:GAIN_W]} + (r_prod[0] ? {1'b0, r_mag} : '0);

        // negative products round toward minus infinity: ceil on the magnitude
        q_mag = {1'b0, r_prod[ACC_W-1:GAIN_FRAC]}
              + Q_W'(r_neg && (r_prod[GAIN_FRAC-1:0] != '0));
        q_lim = r_neg ? SAT_NEG : SAT_POS;
        q_sat = (q_mag > q_lim) ? q_lim : q_mag;
        y_mag = q_sat[IN_W-1:0];
        div_start = (r_state == ST_SAT) && (y_mag > ONE_IN);

        peak_max = (r_omag > r_peak) ? r_omag : r_peak;

        n_state    = r_state;
        n_gain     = r_gain;
        n_cnt      = r_cnt;
        n_prod     = r_prod;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_last     = r_last;
        n_omag     = r_omag;
        n_peak     = r_peak;
        n_o_valid  = r_o_valid && !m_axis_tready;
        n_o_sample = r_o_sample;
        n_o_peak   = r_o_peak;
        n_o_last   = r_o_last;

        if (i_cfg_valid) begin
            n_gain = (i_cfg_data > GAIN_MAX) ? GAIN_MAX : i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_neg   = in_x[IN_W-1];
                    n_mag   = in_x[IN_W-1] ? (~in_x + IN_W'(1)) : in_x;
                    n_last  = s_axis_tlast;
                    n_prod  = {IN_W'(0), r_gain};
                    n_cnt   = MUL_CNT_W'(GAIN_W - 1);
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_prod = {mul_sum, r_prod[GAIN_W-1:1]};
                n_cnt  = r_cnt - MUL_CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = ST_SAT;
                end
            end
            ST_SAT: begin
                if (div_start) begin
                    n_state = ST_DIV;
                end else begin
                    n_omag  = y_mag[PEAK_W-1:0];
                    n_state = ST_OUT;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    n_omag  = ONE_Q - {1'b0, div_quot};
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_sample = r_neg ? (OUT_W'(0) - OUT_W'(r_omag)) : OUT_W'(r_omag);
                    n_o_last   = r_last;
                    n_o_peak   = r_last ? peak_max : '0;
                    n_peak     = r_last ? '0 : peak_max;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_gain    <= GAIN_RESET;
            r_cnt     <= '0;
            r_peak    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_gain    <= n_gain;
            r_cnt     <= n_cnt;
            r_peak    <= n_peak;
            r_o_valid <= n_o_valid;
        end
        r_prod     <= n_prod;
        r_mag      <= n_mag;
        r_neg      <= n_neg;
        r_last     <= n_last;
        r_omag     <= n_omag;
        r_o_sample <= n_o_sample;
        r_o_peak   <= n_o_peak;
        r_o_last   <= n_o_last;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = OUT_TDATA_W'({r_o_peak, r_o_sample});
    assign m_axis_tlast  = r_o_last;

    `MGSCP_ASSERT_IMP(a_peak_only_last, m_axis_tvalid && !m_axis_tlast, r_o_peak == '0,
        "block peak shown on a beat that is not last")
    `MGSCP_ASSERT_IMP(a_div_done_in_div, div_stat.done, r_state == ST_DIV,
        "divider finished outside the clip step")
    `MGSCP_ASSERT_NXT(a_beat_starts_mul, s_axis_tvalid && s_axis_tready, r_state == ST_MUL,
        "accepted beat did not start the multiply")

endmodule
